/* hdl/dse_pkg.sv */
package dse_pkg;

  localparam int DSE_DECK_SIZE   = 53;
  localparam int DSE_RETRY_LIMIT = 16;

  localparam int DIV_W  = 32;
  localparam int N_W    = 16;
  localparam int CARD_W = 8;
  localparam int DRAW_W = 28;

  localparam logic [31:0] GEN_MULT  = 32'h7570_8a59;
  localparam logic [31:0] DRAW_SPAN = 32'h1000_0000;
  localparam int          SUIT_LEN  = 13;

  localparam logic [31:0] SEED_RST  = 32'd1;
  localparam logic [7:0]  JOKER_RST = 8'd64;

  typedef enum logic [2:0] {
    CMD_RESEED  = 3'd0,
    CMD_INIT    = 3'd1,
    CMD_SHUFFLE = 3'd2,
    CMD_DEAL    = 3'd3,
    CMD_RANDOM  = 3'd4
  } dse_cmd_t;

  localparam logic REG_SEED  = 1'b0;
  localparam logic REG_JOKER = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_LIMIT,
    ST_GEN,
    ST_MUL,
    ST_TEST,
    ST_MOD,
    ST_DEAL,
    ST_RD_I,
    ST_RD_J,
    ST_WR_J
  } dse_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [N_W-1:0]   divisor;
  } dse_div_req_t;

  typedef struct packed {
    logic           done;
    logic [N_W-1:0] rem;
  } dse_div_rsp_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] a;
    logic [31:0] b;
    a = s ^ (s << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

/* hdl/dse_rem_unit.sv */
module dse_rem_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dse_pkg::dse_div_req_t req,
  output dse_pkg::dse_div_rsp_t rsp
);
  import dse_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic             run_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DIV_W-1:0] dvd_r;
  logic [N_W-1:0]   dsr_r;
  logic [N_W-1:0]   rem_r;
  logic [N_W:0]     trial;
  logic [N_W-1:0]   rem_nxt;

  // restoring step: shift in one dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_r, dvd_r[DIV_W-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = N_W'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[N_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

/* hdl/deck_shuffle_engine_core.sv */
// Card deck engine: a deck store, a 32-bit xorshift generator and a shared
// bit-serial remainder unit under one sequencer.
//
// Input channel: present in_cmd, in_index and in_bound with start; the beat is
// taken on the clock edge where start is high and busy is low. busy stays high
// while a command runs. Result channel: out_value, out_fallback_used and
// out_error are shown for exactly one cycle with out_strobe high; the
// receiver cannot stall, so the beat is always taken at the end of that cycle.
// Configuration: APB-style port, seed at byte address 0, joker_code at 4;
// pready is tied high, write in the access phase.
//
// Command flow: reseed, unused codes and every error case finish straight
// from idle and never raise busy; deal reads its card and finishes; init
// writes one deck slot per cycle; a random draw runs the acceptance limit,
// the generator tries and the final reduction, and a shuffle step adds the
// swap. The remainder unit works one bit per cycle, once for the acceptance
// limit and once for the final reduction; each generator try steps, scales
// and tests a draw, and the result is registered. One command runs at a time.
// Reset: generator state, deal pointer and fallback offset clear to zero, the
// deck reads as all zero (valid bits), seed returns to 1 and joker_code to 64.
module deck_shuffle_engine_core #(
  parameter int DECK_SIZE   = dse_pkg::DSE_DECK_SIZE,
  parameter int RETRY_LIMIT = dse_pkg::DSE_RETRY_LIMIT
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [5:0]  in_index,
  input  logic [15:0] in_bound,
  // result channel
  output logic        out_strobe,
  output logic [15:0] out_value,
  output logic        out_fallback_used,
  output logic        out_error,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dse_pkg::*;

  localparam int AW  = $clog2(DECK_SIZE);
  localparam int DPW = $clog2(DECK_SIZE + 1);
  localparam int TW  = $clog2(RETRY_LIMIT + 2);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [31:0]       seed_r;
  logic [CARD_W-1:0] joker_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= SEED_RST;
      joker_r <= JOKER_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SEED:  seed_r  <= pwdata;
        REG_JOKER: joker_r <= pwdata[CARD_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SEED:  prdata = seed_r;
      REG_JOKER: prdata = {{(32 - CARD_W){1'b0}}, joker_r};
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer and datapath state
  // ---------------------------------------------------------------------
  dse_state_t state_r, state_nxt;

  logic [31:0]       rng_r;
  logic [31:0]       offset_r;
  logic [DPW-1:0]    dp_r;
  logic [N_W-1:0]    n_r;
  logic [DRAW_W:0]   limit_r;
  logic [DRAW_W-1:0] m_r;
  logic [TW-1:0]     tries_r;
  logic              fb_r;
  logic              shuf_r;
  logic [AW-1:0]     idx_r;
  logic [AW-1:0]     j_r;
  logic [AW-1:0]     sweep_r;
  logic [3:0]        rank_r;
  logic [2:0]        suit_r;
  logic [CARD_W-1:0] ti_r;

  logic          accept;
  logic          idx_bad;
  logic          deal_end;
  logic          rejected;
  logic          retry_left;
  logic          j_same;
  logic          sweep_last;
  logic [31:0]   product;

  dse_div_req_t  div_req;
  dse_div_rsp_t  div_rsp;

  // deck store
  logic [CARD_W-1:0]    deck_mem [DECK_SIZE];
  logic [DECK_SIZE-1:0] valid_r;
  logic [CARD_W-1:0]    rd_data_r;
  logic                 rd_vld_r;
  logic [CARD_W-1:0]    rd_card;

  // control from the output decoder
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CARD_W-1:0] mem_wdata;
  logic [AW-1:0]     rd_addr;
  logic              fin;
  logic [15:0]       fin_value;
  logic              fin_fb;
  logic              fin_err;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start & ~busy;
  assign idx_bad    = {1'b0, in_index} >= 7'(DECK_SIZE);
  assign deal_end   = dp_r >= DPW'(DECK_SIZE);
  assign rejected   = {1'b0, m_r} >= limit_r;
  assign retry_left = tries_r < TW'(RETRY_LIMIT);
  assign j_same     = div_rsp.rem == N_W'(idx_r);
  assign sweep_last = sweep_r == AW'(DECK_SIZE - 1);
  assign product    = rng_r * GEN_MULT;
  assign rd_card    = rd_vld_r ? rd_data_r : '0;

  dse_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_INIT:    state_nxt = ST_INIT;
            CMD_SHUFFLE: if (!idx_bad) state_nxt = ST_LIMIT;
            CMD_DEAL:    if (!deal_end) state_nxt = ST_DEAL;
            CMD_RANDOM:  if (in_bound != '0) state_nxt = ST_LIMIT;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_INIT:  if (sweep_last) state_nxt = ST_IDLE;
      ST_LIMIT: if (div_rsp.done) state_nxt = ST_GEN;
      ST_GEN:   state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_TEST;
      ST_TEST:  state_nxt = (rejected && retry_left) ? ST_GEN : ST_MOD;
      ST_MOD: begin
        if (div_rsp.done) begin
          state_nxt = (shuf_r && !j_same) ? ST_RD_I : ST_IDLE;
        end
      end
      ST_DEAL:  state_nxt = ST_IDLE;
      ST_RD_I:  state_nxt = ST_RD_J;
      ST_RD_J:  state_nxt = ST_WR_J;
      ST_WR_J:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Outputs of the sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    div_req   = '0;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = rd_card;
    rd_addr   = idx_r;
    fin       = 1'b0;
    fin_value = '0;
    fin_fb    = 1'b0;
    fin_err   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        rd_addr = dp_r[AW-1:0];
        div_req.dividend = DRAW_SPAN;
        div_req.divisor  = (in_cmd == CMD_SHUFFLE) ? (N_W'(in_index) + 1'b1) : in_bound;
        if (accept) begin
          case (in_cmd)
            CMD_SHUFFLE: begin
              div_req.start = ~idx_bad;
              fin           = idx_bad;
              fin_err       = idx_bad;
            end
            CMD_DEAL: begin
              fin     = deal_end;
              fin_err = deal_end;
            end
            CMD_RANDOM: begin
              div_req.start = (in_bound != '0);
              fin           = (in_bound == '0);
              fin_err       = (in_bound == '0);
            end
            CMD_INIT: fin = 1'b0;
            default:  fin = 1'b1;   // reseed and unused codes finish at once
          endcase
        end
      end
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        mem_wdata = sweep_last ? joker_r : {1'b0, suit_r, rank_r};
        fin       = sweep_last;
      end
      ST_TEST: begin
        div_req.divisor = n_r;
        if (!(rejected && retry_left)) begin
          div_req.start    = 1'b1;
          div_req.dividend = rejected ? (32'(m_r) + offset_r) : 32'(m_r);
        end
      end
      ST_MOD: begin
        rd_addr = idx_r;
        if (div_rsp.done) begin
          fin       = !shuf_r || j_same;
          fin_value = shuf_r ? '0 : div_rsp.rem;
          fin_fb    = fb_r;
        end
      end
      ST_DEAL: begin
        fin       = 1'b1;
        fin_value = 16'(rd_card);
      end
      ST_RD_I: begin
        rd_addr = j_r;
      end
      ST_RD_J: begin
        // deck[i] takes the partner card
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = rd_card;
      end
      ST_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = ti_r;
        fin       = 1'b1;
        fin_fb    = fb_r;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rng_r      <= '0;
      offset_r   <= '0;
      dp_r       <= '0;
      valid_r    <= '0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_strobe <= fin;
      if (mem_we) begin
        valid_r[mem_waddr] <= 1'b1;
      end
      if (state_r == ST_IDLE && accept && in_cmd == CMD_RESEED) begin
        rng_r <= seed_r;
      end
      if (state_r == ST_GEN) begin
        rng_r <= xorshift32(rng_r);
      end
      // every try rejected: advance the fallback offset by the limit
      if (state_r == ST_TEST && rejected && !retry_left) begin
        offset_r <= offset_r + 32'(limit_r);
      end
      if (state_r == ST_INIT && sweep_last) begin
        dp_r <= '0;
      end
      if (state_r == ST_DEAL) begin
        dp_r <= dp_r + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (fin) begin
      out_value         <= fin_value;
      out_fallback_used <= fin_fb;
      out_error         <= fin_err;
    end
    if (state_r == ST_IDLE && accept) begin
      shuf_r  <= (in_cmd == CMD_SHUFFLE);
      idx_r   <= in_index[AW-1:0];
      n_r     <= div_req.divisor;
      sweep_r <= '0;
      rank_r  <= '0;
      suit_r  <= '0;
    end
    if (state_r == ST_INIT) begin
      sweep_r <= sweep_r + 1'b1;
      if (rank_r == 4'(SUIT_LEN - 1)) begin
        rank_r <= '0;
        suit_r <= suit_r + 1'b1;
      end else begin
        rank_r <= rank_r + 1'b1;
      end
    end
    if (state_r == ST_LIMIT && div_rsp.done) begin
      limit_r <= (DRAW_W + 1)'(DRAW_SPAN) - (DRAW_W + 1)'(div_rsp.rem);
      tries_r <= '0;
    end
    if (state_r == ST_MUL) begin
      m_r <= product[DRAW_W-1:0];
    end
    if (state_r == ST_TEST) begin
      if (rejected && retry_left) begin
        tries_r <= tries_r + 1'b1;
      end
      fb_r <= rejected;
    end
    if (state_r == ST_MOD && div_rsp.done) begin
      j_r <= div_rsp.rem[AW-1:0];
    end
    if (state_r == ST_RD_I) begin
      ti_r <= rd_card;
    end
  end

  // deck store: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      deck_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= deck_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= valid_r[rd_addr];
    end
  end

endmodule

/* sim/deck_shuffle_checker.sv */
`timescale 1ns / 100ps

module deck_shuffle_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [5:0]  in_index,
  input  logic [15:0] in_bound,
  input  logic        out_strobe,
  input  logic [15:0] out_value,
  input  logic        out_fallback_used,
  input  logic        out_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          owed_count,
  output int          results_count,
  output int          error_count,
  output int          fallback_count
);
  import dse_pkg::*;

  localparam int DECK_LEN = DSE_DECK_SIZE;

  typedef struct packed {
    logic [15:0] value;
    logic        fallback_used;
    logic        error;
  } card_result_t;

  card_result_t owed_results[$];
  card_result_t head;

  logic [31:0]       seed_reg;
  logic [7:0]        joker_reg;
  logic [31:0]       gen_state;
  logic [CARD_W-1:0] deck_copy [DECK_LEN];
  logic [5:0]        deal_ptr;
  logic [31:0]       spill_offset;

  int fails;
  int results_n;
  int errors_n;
  int fallbacks_n;

  // advance the xorshift state and return the 28-bit scaled draw
  function automatic logic [DRAW_W-1:0] next_draw();
    logic [31:0] s;
    logic [31:0] prod;
    s = gen_state;
    s = s ^ (s << 13);
    s = s ^ (s >> 17);
    s = s ^ (s << 5);
    gen_state = s;
    prod = s * GEN_MULT;
    return prod[DRAW_W-1:0];
  endfunction

  // unbiased draw in [0,n) with bounded retries, then the offset fallback
  function automatic logic [15:0] pick_below(input logic [15:0] n, output logic fell_back);
    logic [31:0] accept_lim;
    logic [31:0] n_wide;
    logic [31:0] m;
    logic [31:0] r;
    int          tries;
    n_wide     = {16'd0, n};
    accept_lim = DRAW_SPAN - (DRAW_SPAN % n_wide);
    m          = {4'd0, next_draw()};
    tries      = 0;
    while (m >= accept_lim && tries < DSE_RETRY_LIMIT) begin
      m = {4'd0, next_draw()};
      tries++;
    end
    if (m >= accept_lim) begin
      r            = (m + spill_offset) % n_wide;
      spill_offset = spill_offset + accept_lim;
      fell_back    = 1'b1;
    end else begin
      r         = m % n_wide;
      fell_back = 1'b0;
    end
    return r[15:0];
  endfunction

  function automatic card_result_t apply_command(input logic [2:0]  cmd,
                                                 input logic [5:0]  idx,
                                                 input logic [15:0] bnd);
    card_result_t      res;
    logic [15:0]       partner;
    logic [CARD_W-1:0] held;
    logic [31:0]       code;
    logic              fb;
    res = '0;
    case (cmd)
      CMD_RESEED: begin
        gen_state = seed_reg;
      end
      CMD_INIT: begin
        for (int i = 0; i < DECK_LEN - 1; i++) begin
          code         = ((i / SUIT_LEN) << 4) | (i % SUIT_LEN);
          deck_copy[i] = code[CARD_W-1:0];
        end
        deck_copy[DECK_LEN-1] = joker_reg;
        deal_ptr = '0;
      end
      CMD_SHUFFLE: begin
        if (idx >= DECK_LEN) begin
          res.error = 1'b1;
        end else begin
          partner           = pick_below({10'd0, idx} + 16'd1, fb);
          res.fallback_used = fb;
          if (partner < DECK_LEN && partner[5:0] != idx) begin
            held                    = deck_copy[idx];
            deck_copy[idx]          = deck_copy[partner[5:0]];
            deck_copy[partner[5:0]] = held;
          end
        end
      end
      CMD_DEAL: begin
        if (deal_ptr >= DECK_LEN) begin
          res.error = 1'b1;
        end else begin
          res.value = {8'd0, deck_copy[deal_ptr]};
          deal_ptr  = deal_ptr + 6'd1;
        end
      end
      CMD_RANDOM: begin
        if (bnd == '0) begin
          res.error = 1'b1;
        end else begin
          res.value         = pick_below(bnd, fb);
          res.fallback_used = fb;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic flag_field(input string what, input logic [15:0] want_v,
                            input logic [15:0] got_v);
    fails++;
    $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seed_reg     = SEED_RST;
      joker_reg    = JOKER_RST;
      gen_state    = '0;
      deal_ptr     = '0;
      spill_offset = '0;
      for (int i = 0; i < DECK_LEN; i++) deck_copy[i] = '0;
      owed_results.delete();
      fails       = 0;
      results_n   = 0;
      errors_n    = 0;
      fallbacks_n = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_JOKER) joker_reg = pwdata[7:0];
        else seed_reg = pwdata;
      end
      if (start && !busy) owed_results.push_back(apply_command(in_cmd, in_index, in_bound));
      if (out_strobe) begin
        results_n++;
        if (owed_results.size() == 0) begin
          fails++;
          $display("%0t: unexpected result beat: value %h fallback %b error %b",
                   $time, out_value, out_fallback_used, out_error);
        end else begin
          head = owed_results.pop_front();
          if (out_value !== head.value) flag_field("value", head.value, out_value);
          if (out_fallback_used !== head.fallback_used)
            flag_field("fallback_used", {15'd0, head.fallback_used}, {15'd0, out_fallback_used});
          if (out_error !== head.error)
            flag_field("error", {15'd0, head.error}, {15'd0, out_error});
          if (head.error) errors_n++;
          if (head.fallback_used) fallbacks_n++;
        end
      end
    end
    fail_count     <= fails;
    owed_count     <= owed_results.size();
    results_count  <= results_n;
    error_count    <= errors_n;
    fallback_count <= fallbacks_n;
  end

endmodule

/* sim/tb_deck_shuffle_engine_core.sv */
`timescale 1ns / 100ps

module tb_deck_shuffle_engine_core;
  import dse_pkg::*;

  // Stop issuing once this many command beats have gone in.
  localparam int ITEMS_TOTAL   = 1700;
  // Last stretch of the run: sender inserts no random gaps.
  localparam int CALM_FROM     = ITEMS_TOTAL * 85 / 100;
  // Slowest command is a shuffle step with every retry spent; leave a wide margin.
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 150;
  // Codes beyond the defined operations: the block must ignore them.
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_cmd;
  logic [5:0]  in_index;
  logic [15:0] in_bound;
  logic        out_strobe;
  logic [15:0] out_value;
  logic        out_fallback_used;
  logic        out_error;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int owed_count;
  int results_count;
  int error_count;
  int fallback_count;

  int issued;
  int phase;
  int quiet_cycles;
  bit gaps_on;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  deck_shuffle_engine_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_index         (in_index),
    .in_bound         (in_bound),
    .out_strobe       (out_strobe),
    .out_value        (out_value),
    .out_fallback_used(out_fallback_used),
    .out_error        (out_error),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // The checker watches both channels and the register port on its own,
  // keeps a private copy of deck, generator and registers, and reports back
  // how many results are still owed and how many checks failed.
  deck_shuffle_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_index         (in_index),
    .in_bound         (in_bound),
    .out_strobe       (out_strobe),
    .out_value        (out_value),
    .out_fallback_used(out_fallback_used),
    .out_error        (out_error),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .fail_count       (fail_count),
    .owed_count       (owed_count),
    .results_count    (results_count),
    .error_count      (error_count),
    .fallback_count   (fallback_count)
  );

  // Watchdog: any command or result beat restarts the count. A hung
  // sequencer or a lost strobe ends the run here.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat for %0d cycles, %0d results still owed",
               STALL_LIMIT, owed_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Drop start and hold off; n sets how long.
  task automatic idle_for(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Present one command and hold it until the block takes the beat. start is
  // left high on return so back-to-back commands never see it dip.
  task automatic issue(input logic [2:0] cmd, input logic [5:0] idx, input logic [15:0] bnd);
    if (gaps_on && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 6));
    start    <= 1'b1;
    in_cmd   <= cmd;
    in_index <= idx;
    in_bound <= bnd;
    @(posedge clk);
    while (busy) @(posedge clk);
    issued++;
  endtask

  // Stop sending and wait until every owed result has come back, then wait on
  // so the sequencer is surely back in idle.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup phase, access phase until pready, then a return to idle so a
  // following write starts cleanly.
  task automatic cfg_write(input logic reg_sel, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [31:0] seed, input logic [7:0] joker);
    settle();
    cfg_write(REG_SEED, seed);
    cfg_write(REG_JOKER, {24'd0, joker});
  endtask

  // A well-formed hand: optional reseed, fresh deck, Fisher-Yates pass from
  // the top slot downwards, then deal. Most hands deal the whole deck and
  // run past the end to hit the exhausted-deck error.
  task automatic play_round();
    int low_idx;
    int deals;
    if ($urandom_range(0, 1) == 1) issue(CMD_RESEED, 6'($urandom), 16'($urandom));
    issue(CMD_INIT, 6'($urandom), 16'($urandom));
    low_idx = ($urandom_range(0, 3) == 0) ? $urandom_range(1, DSE_DECK_SIZE - 1) : 1;
    for (int i = DSE_DECK_SIZE - 1; i >= low_idx; i--) issue(CMD_SHUFFLE, 6'(i), 16'($urandom));
    deals = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20)
                                         : DSE_DECK_SIZE + $urandom_range(0, 3);
    repeat (deals) issue(CMD_DEAL, 6'($urandom), 16'($urandom));
  endtask

  // Loose commands with random fields: spare codes, bad indexes, zero and
  // awkward bounds mixed in with ordinary draws.
  task automatic play_noise(input int count);
    logic [2:0]  c;
    logic [5:0]  idx;
    logic [15:0] bnd;
    repeat (count) begin
      case ($urandom_range(0, 11))
        0:          c = CMD_RESEED;
        1:          c = CMD_INIT;
        2, 3:       c = CMD_SHUFFLE;
        4, 5:       c = CMD_DEAL;
        6, 7, 8, 9: c = CMD_RANDOM;
        default:    c = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      endcase
      idx = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(DSE_DECK_SIZE, 63))
                                        : 6'($urandom_range(0, DSE_DECK_SIZE - 1));
      case ($urandom_range(0, 7))
        0:       bnd = '0;
        1, 2:    bnd = 16'($urandom_range(1, 64));
        3:       bnd = 16'hFFFF - 16'($urandom_range(0, 3));
        default: bnd = 16'($urandom);
      endcase
      issue(c, idx, bnd);
    end
  endtask

  initial begin
    int seg_end;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_cmd   = CMD_RESEED;
    in_index = '0;
    in_bound = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    issued   = 0;
    phase    = 0;
    gaps_on  = 1'b1;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, on the register values left by reset.
    // Deck is still all zero and the generator sits at zero before reseed.
    issue(CMD_DEAL, 0, 0);
    issue(CMD_RANDOM, 6'h3F, 16'hFFFF);
    issue(CMD_SHUFFLE, 6'(DSE_DECK_SIZE - 1), 0);
    // Reseed from the reset seed, build the deck with the reset joker code.
    issue(CMD_RESEED, 0, 0);
    issue(CMD_INIT, 0, 0);
    issue(CMD_DEAL, 0, 0);
    // Smallest shuffle range: the only partner is the slot itself.
    issue(CMD_SHUFFLE, 0, 0);
    issue(CMD_SHUFFLE, 6'(DSE_DECK_SIZE - 1), 16'hFFFF);
    // Shuffle index just past the deck and at the field maximum.
    issue(CMD_SHUFFLE, 6'(DSE_DECK_SIZE), 0);
    issue(CMD_SHUFFLE, 6'h3F, 16'hFFFF);
    // Zero bound, then the smallest and largest bounds and a few in between.
    issue(CMD_RANDOM, 0, 0);
    issue(CMD_RANDOM, 0, 1);
    issue(CMD_RANDOM, 6'h3F, 16'hFFFF);
    issue(CMD_RANDOM, 0, 16'h8000);
    issue(CMD_RANDOM, 0, 16'h8001);
    issue(CMD_RANDOM, 0, 3);
    issue(CMD_DEAL, 6'h3F, 16'hFFFF);
    // Spare command codes must change nothing and answer all zero.
    issue(CMD_SPARE_FIRST, 6'h3F, 16'hFFFF);
    issue(CMD_SPARE_LAST, 0, 0);
    issue(CMD_DEAL, 0, 0);

    // Random part, split into phases with a fresh register setting each.
    // Every phase boundary drains the block first.
    while (issued < ITEMS_TOTAL) begin
      case (phase % 5)
        0:       reconfigure(32'h0000_0000, 8'hFF);
        1:       reconfigure(32'hFFFF_FFFF, 8'h00);
        2:       reconfigure($urandom, 8'($urandom));
        3:       reconfigure(32'h8000_0000, 8'($urandom));
        default: reconfigure(SEED_RST, JOKER_RST);
      endcase
      phase++;
      seg_end = issued + 250;
      while (issued < seg_end && issued < ITEMS_TOTAL) begin
        // Some stretches run with no sender gaps at all; the tail always does.
        gaps_on = (issued < CALM_FROM) && ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 2) == 0) play_round();
        else play_noise($urandom_range(5, 30));
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d commands across %0d register settings, %0d results checked",
             issued, phase + 1, results_count);
    $display("Error responses seen: %0d, fallback draws seen: %0d", error_count, fallback_count);
    if (owed_count != 0) $display("%0d results never arrived", owed_count);
    if (fail_count == 0 && owed_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
